// ===== hdl/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, constants, command/status types and helpers for the
// Taylor-series sine block.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int IDX_W      = 16;
  localparam int PERIOD_W   = 16;
  localparam int TERM_W     = 4;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_TERMS_DEF = 8;

  localparam int FRAC_BITS = 29;
  localparam logic [31:0] TWO_PI_Q29 = 32'hC90F_DAA2;

  // Divider: 48-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int DIV_W  = 48;
  localparam int DIVR_W = 16;

  // Multiplier operands are split into two 18-bit halves of the first operand
  localparam int MUL_W  = 36;
  localparam int HALF_W = 18;
  localparam int PART_W = HALF_W + MUL_W;
  localparam int PROD_W = 2 * MUL_W;

  localparam int ACC_W  = 40;
  localparam int RND_W  = ACC_W + 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 8'd1;

  typedef enum logic [1:0] {
    DIV_MOD  = 2'd0,
    DIV_ANG  = 2'd1,
    DIV_TERM = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_RC = 2'd0,
    MUL_XX = 2'd1,
    MUL_TX = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic              load;
    logic              div_start;
    div_sel_t          div_sel;
    logic              mul_en;
    logic              mul_hi;
    mul_sel_t          mul_sel;
    logic              ld_r;
    logic              ld_x;
    logic              ld_x2;
    logic              ld_t;
    logic              acc_add;
    logic              acc_neg;
    logic              out_load;
    logic [TERM_W-1:0] term;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // Ratio of successive factorial reciprocals: (2j)*(2j+1)
  function automatic logic [DIVR_W-1:0] term_div(input logic [TERM_W-1:0] j);
    logic [TERM_W:0] a;
    logic [TERM_W:0] b;
    begin
      a = {j, 1'b0};
      b = {j, 1'b1};
      term_div = DIVR_W'(a * b);
    end
  endfunction

endpackage

// ===== hdl/taylor_series_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_series_sine
// Truncated Taylor-series sine of 2*pi*angle_index/period, Q16.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: angle_index is taken at a rising edge with start high
//   and busy low. busy stays high until the result has been produced.
//   Result transaction: sine_value and saturated are shown for exactly one
//   cycle with result_valid high. The receiver cannot stall; it must take
//   the result in that cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 = period,
//   1 = term_count, other indexes ignored. cfg_ready is always high; write
//   only while busy is low.
//   Each transaction runs the shared one-bit-per-cycle divider (index
//   reduction, angle scaling, one division per extra term) and the split
//   multiplier, whose first operand is taken in low and high halves. One
//   transaction at a time; busy drops as the result is shown.
//   Reset: period = 1, term_count = 4, controller idle, no result pending.
// ----------------------------------------------------------------------------
module taylor_series_sine #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [tss_pkg::IDX_W-1:0]      angle_index,
  output logic                           result_valid,
  output logic signed [tss_pkg::OUT_W-1:0] sine_value,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tss_pkg::*;

  logic [PERIOD_W-1:0] period;
  logic [TERM_W-1:0]   term_count;
  cmd_t                cmd;
  status_t             status;

  // Configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_W'(1);
      term_count <= TERM_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD:     period     <= cfg_data;
        REG_TERM_COUNT: term_count <= cfg_data[TERM_W-1:0];
        default: ;
      endcase
    end
  end

  tss_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .term_count (term_count),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  tss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .angle_index  (angle_index),
    .period       (period),
    .sine_value   (sine_value),
    .saturated    (saturated),
    .result_valid (result_valid)
  );

  // An accepted transaction keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  // Result strobe follows the output load, and only it
  a_out_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid == $past(cmd.out_load))
    else $error("result strobe without output load");

  // One result per transaction: the strobe is never held high
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held");

  // Clipped results sit at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      (sine_value == 32'sh7FFF_FFFF) || (sine_value == 32'sh8000_0000))
    else $error("saturated result not at a rail");

endmodule

// ===== hdl/tss_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module tss_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tss_pkg::DIV_W-1:0]  dividend,
  input  logic [tss_pkg::DIVR_W-1:0] divisor,
  output logic [tss_pkg::DIV_W-1:0]  quotient,
  output logic [tss_pkg::DIVR_W-1:0] remainder,
  output logic                       done
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] rem_next;
  logic [DIV_W-1:0]  quo;
  logic [DIVR_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [DIVR_W+1:0] trial;
  logic              qbit;

  assign trial    = {1'b0, rem, quo[DIV_W-1]} - {2'b00, dvs};
  assign qbit     = ~trial[DIVR_W+1];
  assign rem_next = qbit ? trial[DIVR_W-1:0] : {rem[DIVR_W-2:0], quo[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], qbit};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/tss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_dp
// Datapath: operand registers, split multiplier, shared divider, Q29
// accumulator and Q16.16 round/saturate output register.
// ----------------------------------------------------------------------------
module tss_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  tss_pkg::cmd_t                cmd,
  output tss_pkg::status_t             status,
  input  logic [tss_pkg::IDX_W-1:0]    angle_index,
  input  logic [tss_pkg::PERIOD_W-1:0] period,
  output logic signed [tss_pkg::OUT_W-1:0] sine_value,
  output logic                         saturated,
  output logic                         result_valid
);
  import tss_pkg::*;

  logic [IDX_W-1:0]        idx;
  logic                    pzero;
  logic [PERIOD_W-1:0]     r;
  logic [MUL_W-1:0]        x;
  logic [MUL_W-1:0]        x2;
  logic [MUL_W-1:0]        t;
  logic [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0] acc;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [HALF_W-1:0] mul_half;
  logic [PART_W-1:0] partial;

  logic [DIV_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [DIV_W-1:0]  div_quot;
  logic [DIVR_W-1:0] div_rem;
  logic              div_done;

  logic signed [RND_W-1:0] rounded;
  logic                    over_hi;
  logic                    over_lo;

  always_comb begin
    case (cmd.mul_sel)
      MUL_RC: begin
        mul_a = MUL_W'(r);
        mul_b = MUL_W'(TWO_PI_Q29);
      end
      MUL_XX: begin
        mul_a = x;
        mul_b = x;
      end
      MUL_TX: begin
        mul_a = t;
        mul_b = x2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_half = cmd.mul_hi ? mul_a[MUL_W-1:HALF_W] : mul_a[HALF_W-1:0];
  assign partial  = PART_W'(mul_half * mul_b);

  always_comb begin
    case (cmd.div_sel)
      DIV_MOD: begin
        div_dividend = DIV_W'(idx);
        div_divisor  = period;
      end
      DIV_ANG: begin
        div_dividend = prod[DIV_W-1:0];
        div_divisor  = period;
      end
      DIV_TERM: begin
        div_dividend = DIV_W'(prod[PROD_W-1:FRAC_BITS]);
        div_divisor  = term_div(cmd.term);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  tss_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx   <= angle_index;
      pzero <= (period == '0);
      acc   <= '0;
    end
    if (cmd.mul_en) begin
      prod <= cmd.mul_hi ? prod + {partial, {HALF_W{1'b0}}} : PROD_W'(partial);
    end
    if (cmd.ld_r) r <= div_rem;
    if (cmd.ld_x) begin
      x <= pzero ? '0 : MUL_W'(div_quot[31:0]);
      t <= pzero ? '0 : MUL_W'(div_quot[31:0]);
    end
    if (cmd.ld_x2) x2 <= prod[MUL_W+FRAC_BITS-1:FRAC_BITS];
    if (cmd.ld_t) t <= div_quot[MUL_W-1:0];
    if (cmd.acc_add) begin
      acc <= cmd.acc_neg ? acc - ACC_W'(t) : acc + ACC_W'(t);
    end
  end

  // Round half up to Q16.16, then clip
  assign rounded = (RND_W'(acc) + RND_W'(4096)) >>> 13;
  assign over_hi = rounded > RND_W'(64'sh7FFF_FFFF);
  assign over_lo = rounded < -RND_W'(64'sh8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      saturated <= over_hi | over_lo;
      if (over_hi) sine_value <= 32'sh7FFF_FFFF;
      else if (over_lo) sine_value <= 32'sh8000_0000;
      else sine_value <= rounded[OUT_W-1:0];
    end
  end

endmodule

// ===== hdl/tss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: reduction, angle scaling, x^2, then one pass per series term.
// ----------------------------------------------------------------------------
module tss_ctrl #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tss_pkg::TERM_W-1:0] term_count,
  input  tss_pkg::status_t           status,
  output tss_pkg::cmd_t              cmd,
  output logic                       busy
);
  import tss_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_MOD_GO   = 15'b000000000000010,
    S_MOD_WAIT = 15'b000000000000100,
    S_RC_M0    = 15'b000000000001000,
    S_RC_M1    = 15'b000000000010000,
    S_ANG_GO   = 15'b000000000100000,
    S_ANG_WAIT = 15'b000000001000000,
    S_XX_M0    = 15'b000000010000000,
    S_XX_M1    = 15'b000000100000000,
    S_ACC      = 15'b000001000000000,
    S_TX_M0    = 15'b000010000000000,
    S_TX_M1    = 15'b000100000000000,
    S_TD_GO    = 15'b001000000000000,
    S_TD_WAIT  = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [TERM_W-1:0] n;
  logic [TERM_W-1:0] term;
  logic              last_term;

  assign busy      = (state != S_IDLE);
  assign last_term = (term == n - 1'b1);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.term   = term;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MOD;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (status.div_done) begin
          cmd.ld_r   = 1'b1;
          state_next = S_RC_M0;
        end
      end
      S_RC_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RC;
        state_next  = S_RC_M1;
      end
      S_RC_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = MUL_RC;
        state_next  = S_ANG_GO;
      end
      S_ANG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ANG;
        state_next    = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        if (status.div_done) begin
          cmd.ld_x   = 1'b1;
          state_next = S_XX_M0;
        end
      end
      S_XX_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XX;
        state_next  = S_XX_M1;
      end
      S_XX_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = MUL_XX;
        state_next  = S_ACC;
      end
      S_ACC: begin
        // first visit: product still holds x*x
        cmd.ld_x2 = (term == '0);
        if (n == '0) begin
          state_next = S_DONE;
        end else begin
          cmd.acc_add = 1'b1;
          cmd.acc_neg = term[0];
          state_next  = last_term ? S_DONE : S_TX_M0;
        end
      end
      S_TX_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TX;
        state_next  = S_TX_M1;
      end
      S_TX_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = MUL_TX;
        state_next  = S_TD_GO;
      end
      S_TD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TERM;
        state_next    = S_TD_WAIT;
      end
      S_TD_WAIT: begin
        cmd.div_sel = DIV_TERM;
        if (status.div_done) begin
          cmd.ld_t   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        term <= '0;
        n    <= ((TERM_W + 1)'(term_count) > (TERM_W + 1)'(MAX_TERMS)) ?
                TERM_W'(MAX_TERMS) : term_count;
      end else if (state == S_ACC && n != '0 && !last_term) begin
        term <= term + 1'b1;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for taylor_series_sine: a bit-exact fixed-point sine
// predictor fed by directed and random angle transactions across many
// period / term_count settings; every result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import tss_pkg::*;

  // result of one sine evaluation
  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    clipped;
  } sine_res_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [IDX_W-1:0]        angle_index;
  logic                    result_valid;
  logic signed [OUT_W-1:0] sine_value;
  logic                    saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // local copy of the block's registers
  logic [PERIOD_W-1:0] cur_period;
  logic [TERM_W-1:0]   cur_terms;

  sine_res_t pending_sines[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  bit        no_gaps;   // stretch where the sender never idles

  taylor_series_sine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .angle_index(angle_index), .result_valid(result_valid),
    .sine_value(sine_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // floor(a*b / 2^29) from a full-width product, kept to 64 bits
  function automatic logic [63:0] q29_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    begin
      p = a * b;
      q29_mul = p[92:29];
    end
  endfunction

  // Series sine of index idx under the current register settings
  function automatic sine_res_t sine_of(input logic [IDX_W-1:0] idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        r;
    logic signed [63:0] acc;
    logic signed [63:0] q;
    int                 n;
    sine_res_t          res;
    begin
      x = 0;
      if (cur_period != 0) begin
        r = idx % cur_period;
        x = (r * 64'(TWO_PI_Q29)) / cur_period;
      end
      n = (cur_terms > 8) ? 8 : int'(cur_terms);
      x2 = q29_mul(x, x);
      t = x;
      acc = 0;
      for (int j = 0; j < n; j++) begin
        if (j > 0)
          t = q29_mul(t, x2) / (64'(2 * j) * 64'(2 * j + 1));
        if (j % 2 == 0) acc = acc + $signed(t);
        else acc = acc - $signed(t);
      end
      // round half up to Q16.16: floor((acc + 2^12) / 2^13)
      q = (acc + 64'sd4096) >>> 13;
      res.clipped = 1'b0;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647;
        res.clipped = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648;
        res.clipped = 1'b1;
      end
      res.value = q[31:0];
      sine_of = res;
    end
  endfunction

  // Checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_sines.size() == 0) begin
        $display("%0t ERROR: result with none expected: value %0d sat %0b",
                 $time, sine_value, saturated);
        n_errors++;
      end else begin
        sine_res_t e;
        e = pending_sines.pop_front();
        n_checked++;
        if (sine_value !== e.value) begin
          $display("%0t ERROR: sine_value expected %0d actual %0d",
                   $time, e.value, sine_value);
          n_errors++;
        end
        if (saturated !== e.clipped) begin
          $display("%0t ERROR: saturated expected %0b actual %0b",
                   $time, e.clipped, saturated);
          n_errors++;
        end
      end
    end
  end

  // One angle transaction. start is left high afterwards so back-to-back
  // items need no extra edge; callers idling lower it.
  task automatic send_angle(input logic [IDX_W-1:0] idx);
    begin
      if (!no_gaps && $urandom_range(99) < 9) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
      start       <= 1'b1;
      angle_index <= idx;
      do @(posedge clk); while (busy);
      pending_sines.push_back(sine_of(idx));
      n_sent++;
    end
  endtask

  // Wait until every expected result has arrived, then a short settle
  task automatic drain;
    begin
      start <= 1'b0;
      while (pending_sines.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  // Register write on the config channel, only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] d);
    begin
      drain();
      cfg_valid <= 1'b1;
      cfg_index <= ri;
      cfg_data  <= d;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      if (ri == REG_PERIOD) cur_period = d;
      else if (ri == REG_TERM_COUNT) cur_terms = d[TERM_W-1:0];
    end
  endtask

  // Reset values, field extremes and each special case
  task automatic test_directed;
    begin
      send_angle(16'd0);
      send_angle(16'hFFFF);
      write_reg(REG_PERIOD, 16'hFFFF);
      write_reg(REG_TERM_COUNT, 16'd8);
      send_angle(16'd0);
      send_angle(16'd16383);
      send_angle(16'd32767);
      send_angle(16'd49151);
      send_angle(16'hFFFE);
      send_angle(16'hFFFF);
      // zero terms: sum is zero
      write_reg(REG_TERM_COUNT, 16'd0);
      send_angle(16'd40000);
      // count above the maximum saturates
      write_reg(REG_TERM_COUNT, 16'd15);
      send_angle(16'hFFFE);
      // upper data bits beyond the field are dropped
      write_reg(REG_TERM_COUNT, 16'hFFF3);
      send_angle(16'd20000);
      // period zero: angle taken as zero
      write_reg(REG_PERIOD, 16'd0);
      send_angle(16'd1234);
      // writes to unknown indexes are ignored
      write_reg(8'd2, 16'd7);
      write_reg(8'hFF, 16'hFFFF);
      write_reg(REG_PERIOD, 16'd4);
      write_reg(REG_TERM_COUNT, 16'd1);
      for (int i = 0; i < 5; i++) send_angle(IDX_W'(i));
      write_reg(REG_TERM_COUNT, 16'd8);
      for (int i = 0; i < 4; i++) send_angle(IDX_W'(i));
      drain();
    end
  endtask

  // Random phases, each with its own register setting
  task automatic test_random;
    logic [CFG_DATA_W-1:0] p;
    begin
      for (int ph = 0; ph < 37; ph++) begin
        case ($urandom_range(4))
          0: p = 16'hFFFF;
          1: p = 16'd1;
          2: p = CFG_DATA_W'($urandom_range(16, 2));
          default: p = CFG_DATA_W'($urandom_range(16'hFFFF));
        endcase
        if (ph == 5) p = 16'd0;
        write_reg(REG_PERIOD, p);
        write_reg(REG_TERM_COUNT,
                  (ph % 4 == 0) ? 16'd8 : CFG_DATA_W'($urandom_range(16'hFFFF)));
        no_gaps = (ph == 10);
        for (int k = 0; k < 50; k++) begin
          // the sender holds off once until the block has gone quiet
          if (ph == 20 && k == 25) drain();
          send_angle(IDX_W'($urandom_range(16'hFFFF)));
        end
        no_gaps = 1'b0;
      end
      drain();
    end
  endtask

  initial begin
    start       = 1'b0;
    angle_index = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cur_period  = 16'd1;
    cur_terms   = 4'd4;
    n_errors    = 0;
    n_checked   = 0;
    n_sent      = 0;
    no_gaps     = 1'b0;
    rst         = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();

    repeat (20) @(posedge clk);
    $display("Run covered %0d angle transactions, %0d results checked, over",
             n_sent, n_checked);
    $display("periods 0..65535 and term counts 0..15 including the extremes.");
    if (n_errors == 0 && pending_sines.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tss_pkg.sv
hdl/tss_div.sv
hdl/tss_dp.sv
hdl/tss_ctrl.sv
hdl/taylor_series_sine.sv
tb/tb.sv
